// ===== rtl/tpb_pkg.sv =====
// Package for the timer pool bank: command codes, status codes, and the
// command and token types shared by the controller and the timer cells.
// No dependencies.
package tpb_pkg;

  // Default size of the pool.
  localparam int NUM_TIMERS_DEFAULT = 8;

  // Most expiries reported for one tick.
  localparam int MAX_RESULTS = 8;

  // Widths fixed by the item fields.
  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 32;
  localparam int STEP_W   = 10;

  // Reset value of the tick step.
  localparam logic [STEP_W-1:0] STEP_RESET = 10'd1;

  // Command codes carried in the input tuser field.
  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_REGISTER   = 3'd1,
    ACT_UNREGISTER = 3'd2,
    ACT_START      = 3'd3,
    ACT_STOP       = 3'd4,
    ACT_NOTIFY     = 3'd5
  } action_t;

  // Status codes of an acknowledge.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Result kinds carried in the output tuser field.
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Command broadcast to every cell while a sweep runs.
  typedef struct packed {
    action_t               action;
    logic [SLOT_W-1:0]     idx;
    logic                  periodic;
    logic [PERIOD_W-1:0]   period;
    logic                  notify;
    logic [STEP_W-1:0]     step;
  } cmd_t;

  // Token handed from cell to cell, one cell per cycle while the chain is not held.
  typedef struct packed {
    logic              valid;
    logic              claimed;
    logic [SLOT_W-1:0] slot;
    logic              ok;
  } tok_t;

endpackage

// ===== rtl/tpb_cell.sv =====
// One timer of the pool: its flags, period and elapsed count, updated when
// the sweep token passes through. Depends on tpb_pkg.
module tpb_cell
  import tpb_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic hold,
  input  cmd_t cmd,
  input  tok_t tok_in,
  output tok_t tok_out,
  output logic expiry
);

  localparam logic [6:0] CELL_ID = 7'(CELL_INDEX);

  tok_t                tok;
  logic                is_reg;
  logic                running;
  logic                periodic;
  logic                notify;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] count;

  logic              act;
  logic              match;
  logic [PERIOD_W:0] sum;
  logic              reached;
  logic              claim;
  logic              start_ok;

  // Decode what this cell does with the token that sits in it.
  always_comb begin
    act      = tok.valid && !hold;
    match    = (CELL_ID == {4'b0, cmd.idx});
    sum      = {1'b0, count} + {{(PERIOD_W + 1 - STEP_W){1'b0}}, cmd.step};
    reached  = (sum >= {1'b0, period});
    claim    = (cmd.action == ACT_REGISTER) && !tok.claimed && !is_reg;
    start_ok = (cmd.action == ACT_START) && match && is_reg &&
               (cmd.period != '0);
    expiry   = act && (cmd.action == ACT_TICK) && is_reg && running &&
               reached && notify;
  end

  // The token moves on with what this cell found.
  always_comb begin
    tok_out = tok;
    if (claim) begin
      tok_out.claimed = 1'b1;
      tok_out.slot    = CELL_ID[SLOT_W-1:0];
    end
    if (start_ok) begin
      tok_out.ok = 1'b1;
    end
  end

  // Token register and timer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok      <= '0;
      is_reg   <= 1'b0;
      running  <= 1'b0;
      periodic <= 1'b0;
      notify   <= 1'b0;
      period   <= '0;
      count    <= '0;
    end else if (!hold) begin
      tok <= tok_in;
      if (tok.valid) begin
        case (cmd.action)
          ACT_TICK: begin
            if (is_reg && running) begin
              if (reached) begin
                if (!periodic) begin
                  running <= 1'b0;
                end
                count <= '0;
              end else begin
                count <= sum[PERIOD_W-1:0];
              end
            end
          end
          ACT_REGISTER: begin
            if (claim) begin
              is_reg   <= 1'b1;
              running  <= 1'b0;
              periodic <= 1'b0;
              notify   <= 1'b0;
              period   <= '0;
              count    <= '0;
            end
          end
          ACT_UNREGISTER: begin
            if (match) begin
              is_reg  <= 1'b0;
              running <= 1'b0;
              notify  <= 1'b0;
            end
          end
          ACT_START: begin
            if (start_ok) begin
              periodic <= cmd.periodic;
              period   <= cmd.period;
              count    <= '0;
              running  <= 1'b1;
            end
          end
          ACT_STOP: begin
            if (match) begin
              running <= 1'b0;
              count   <= '0;
            end
          end
          ACT_NOTIFY: begin
            if (match) begin
              notify <= cmd.notify;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/tpb_ctrl.sv =====
// Sequencer of the timer pool bank: takes commands, launches the sweep
// token, collects expiries and drives the result register. Depends on tpb_pkg.
module tpb_ctrl
  import tpb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [39:0]           in_data,
  input  logic [2:0]            in_user,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_data,
  output logic                  out_user,
  output logic                  out_last,
  input  logic                  cfg_wr_en,
  input  logic [STEP_W-1:0]     cfg_wr_data,
  output cmd_t                  cmd,
  output tok_t                  launch,
  output logic                  hold,
  input  logic [NUM_TIMERS-1:0] ev_vec,
  input  tok_t                  end_tok
);

  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

  state_t            state;
  logic              launch_valid;
  logic              pend;
  logic [SLOT_W-1:0] pend_slot;
  logic [CNT_W-1:0]  exp_cnt;
  tok_t              fin;
  logic [SLOT_W-1:0] out_slot;
  logic [1:0]        out_status;
  logic              ev_any;
  logic [SLOT_W-1:0] ev_slot;

  // The chain stalls while a result waits that cannot yet be replaced.
  assign hold     = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE);
  assign out_data = {3'b0, out_status, out_slot};

  always_comb begin
    launch       = '0;
    launch.valid = launch_valid;
  end

  // At most one cell flags an expiry in a cycle; pick out its slot.
  always_comb begin
    ev_any  = |ev_vec;
    ev_slot = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (ev_vec[i]) begin
        ev_slot = ev_slot | SLOT_W'(i);
      end
    end
  end

  // State, command registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch_valid <= 1'b0;
      pend         <= 1'b0;
      exp_cnt      <= '0;
      out_valid    <= 1'b0;
      cmd.step     <= STEP_RESET;
    end else begin
      if (cfg_wr_en) begin
        cmd.step <= cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (!hold) begin
        launch_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (action_t'(in_user))
              ACT_TICK, ACT_REGISTER, ACT_UNREGISTER,
              ACT_START, ACT_STOP, ACT_NOTIFY: begin
                cmd.action   <= action_t'(in_user);
                cmd.idx      <= in_data[2:0];
                cmd.periodic <= in_data[3];
                cmd.period   <= in_data[35:4];
                cmd.notify   <= in_data[36];
                launch_valid <= 1'b1;
                exp_cnt      <= '0;
                pend         <= 1'b0;
                state        <= S_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (!hold) begin
            // A new expiry pushes the one held back; the last stays pending.
            if (ev_any && (exp_cnt < CNT_W'(MAX_RESULTS))) begin
              if (pend) begin
                out_valid  <= 1'b1;
                out_user   <= KIND_EXPIRY;
                out_slot   <= pend_slot;
                out_status <= ST_OK;
                out_last   <= 1'b0;
              end
              pend      <= 1'b1;
              pend_slot <= ev_slot;
              exp_cnt   <= exp_cnt + 1'b1;
            end
            if (end_tok.valid) begin
              fin   <= end_tok;
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (!hold) begin
            if (cmd.action == ACT_TICK) begin
              if (pend) begin
                out_valid  <= 1'b1;
                out_user   <= KIND_EXPIRY;
                out_slot   <= pend_slot;
                out_status <= ST_OK;
                out_last   <= 1'b1;
              end
              pend <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              out_user  <= KIND_ACK;
              out_last  <= 1'b1;
              out_slot  <= '0;
              out_status <= ST_OK;
              if (cmd.action == ACT_REGISTER) begin
                if (fin.claimed) begin
                  out_slot <= fin.slot;
                end else begin
                  out_status <= ST_NO_FREE;
                end
              end else if (cmd.action == ACT_START && !fin.ok) begin
                out_status <= ST_REJECT;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The report cap is never exceeded.
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    exp_cnt <= CNT_W'(MAX_RESULTS))
    else $error("expiry count above cap");

  // No cell flags an expiry while no sweep runs.
  a_idle_no_ev: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (ev_vec == '0))
    else $error("expiry outside a sweep");

  // Nothing is left pending once the block is back to idle.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend)
    else $error("pending expiry lost");

  // The token leaves the chain only during a sweep.
  a_end_in_sweep: assert property (@(posedge clk) disable iff (rst)
    end_tok.valid |-> (state == S_SWEEP))
    else $error("token out of the chain outside a sweep");

endmodule

// ===== rtl/timer_pool_bank.sv =====
// Top level of the timer pool bank: controller and a chain of timer cells.
// Depends on tpb_pkg, tpb_cell and tpb_ctrl.
//
// Commands arrive on the s_axis channel (tuser carries the action code) and
// results leave on the m_axis channel (tuser carries the kind, tlast marks
// the final result of a command). The user must write the tick step through
// cfg_wr_en and cfg_wr_data only while the block is idle; it is not enforced.
// Every accepted command sends a token along the row of NUM_TIMERS cells,
// one cell per cycle while the row is not held; each cell updates its own
// timer as the token passes. The acknowledge or final expiry of a command is
// presented once the token has left the last cell and the controller has
// passed through its finish state; no new command is taken before the block
// is idle again, so the sweep length of the cell row sets the rate.
// Expiries of a tick come out in ascending timer order, at most eight.
// Actions six and seven are taken and produce nothing.
// After reset all timers are free and idle and the step is one millisecond.
// While a result waits on a stalled receiver the cell row holds still; one
// result can wait in the output register while a new command is accepted.
module timer_pool_bank
  import tpb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // Bits from 0: timer_index[2:0], periodic[3], period[35:4],
  // notify_enable[36], zero fill[39:37].
  input  logic [39:0]       s_axis_tdata,
  // Bits from 0: action[2:0].
  input  logic [2:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // Bits from 0: timer_slot[2:0], status[4:3], zero fill[7:5].
  output logic [7:0]        m_axis_tdata,
  // Bits from 0: kind[0].
  output logic              m_axis_tuser,
  output logic              m_axis_tlast,
  input  logic              cfg_wr_en,
  input  logic [STEP_W-1:0] cfg_wr_data
);

  cmd_t                  cmd;
  logic                  hold;
  tok_t                  chain [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0] ev_vec;
  logic [NUM_TIMERS-1:0] tok_vec;

  tpb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_data     (s_axis_tdata),
    .in_user     (s_axis_tuser),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_user    (m_axis_tuser),
    .out_last    (m_axis_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .launch      (chain[0]),
    .hold        (hold),
    .ev_vec      (ev_vec),
    .end_tok     (chain[NUM_TIMERS])
  );

  // The row of timer cells, each feeding its neighbour.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    tpb_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .hold    (hold),
      .cmd     (cmd),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .expiry  (ev_vec[i])
    );
    assign tok_vec[i] = chain[i+1].valid;
  end

  // Only one token is ever in flight.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({chain[0].valid, tok_vec}))
    else $error("more than one sweep token in the chain");

  // A command is taken only while no token is in flight.
  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> (tok_vec == '0) && !chain[0].valid)
    else $error("command taken during a sweep");

  // A stalled chain keeps its token in place.
  a_hold_token: assert property (@(posedge clk) disable iff (rst)
    hold |=> $stable(tok_vec))
    else $error("token moved while the chain was held");

endmodule

// ===== bench/timer_pool_bank_tb.sv =====
// Self-checking testbench for timer_pool_bank: directed and random command streams.
// It checks every result against an in-bench prediction of the timer bank.
// Depends on tpb_pkg and timer_pool_bank only.
module timer_pool_bank_tb;
  import tpb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = NUM_TIMERS_DEFAULT;
  // One sweep of the cell row plus the pipeline around it.
  localparam int SWEEP_CYCLES = NT + 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 100;

  // Action codes outside the defined set; the block takes them silently.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  // One expected result, as it leaves the master side.
  typedef struct packed {
    logic       kind;
    logic [2:0] slot;
    logic [1:0] status;
    logic       last;
  } pool_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [STEP_W-1:0] cfg_wr_data = '0;

  // Predicted bank state.
  logic        timer_registered [NT];
  logic        timer_running [NT];
  logic        timer_periodic [NT];
  logic        timer_notify [NT];
  logic [31:0] timer_period [NT];
  logic [31:0] timer_count [NT];
  logic [STEP_W-1:0] step_model;

  pool_result_t awaited_results [$];
  pool_result_t oldest;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  timer_pool_bank u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish, %0d results still awaited", $time,
               awaited_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Compare every result transaction with the oldest awaited result.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display({"%0t: unexpected result, expected none, ",
                    "actual kind=%0b slot=%0d status=%0d last=%0b"},
                   $time, m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[4:3], m_axis_tlast);
        errors++;
      end else begin
        oldest = awaited_results.pop_front();
        if (m_axis_tuser !== oldest.kind) begin
          if (errors < MAX_REPORTS)
            $display("%0t: kind mismatch, expected %0b actual %0b", $time, oldest.kind,
                     m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[2:0] !== oldest.slot) begin
          if (errors < MAX_REPORTS)
            $display("%0t: timer_slot mismatch, expected %0d actual %0d", $time, oldest.slot,
                     m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[4:3] !== oldest.status) begin
          if (errors < MAX_REPORTS)
            $display("%0t: status mismatch, expected %0d actual %0d", $time, oldest.status,
                     m_axis_tdata[4:3]);
          errors++;
        end
        if (m_axis_tlast !== oldest.last) begin
          if (errors < MAX_REPORTS)
            $display("%0t: last mismatch, expected %0b actual %0b", $time, oldest.last,
                     m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Update the predicted bank for one accepted command and queue its results.
  function automatic void apply_pool_command(input logic [2:0] act, input logic [2:0] idx,
                                             input logic per, input logic [31:0] period,
                                             input logic ntf);
    pool_result_t r;
    logic [32:0]  sum;
    int           hits;
    int           i;
    logic         found;
    r = '{kind: KIND_ACK, slot: 3'd0, status: ST_OK, last: 1'b1};
    hits = 0;
    found = 1'b0;
    case (act)
      ACT_TICK: begin
        for (i = 0; i < NT; i++) begin
          if (timer_registered[i] && timer_running[i]) begin
            // The sum is one bit wider so that a count near the top cannot wrap.
            sum = {1'b0, timer_count[i]} + {23'd0, step_model};
            if (sum >= {1'b0, timer_period[i]}) begin
              if (timer_notify[i] && hits < MAX_RESULTS) begin
                awaited_results.push_back('{kind: KIND_EXPIRY, slot: i[2:0], status: ST_OK,
                                            last: 1'b0});
                hits++;
              end
              if (!timer_periodic[i])
                timer_running[i] = 1'b0;
              timer_count[i] = '0;
            end else begin
              timer_count[i] = sum[31:0];
            end
          end
        end
        // Only the final expiry of a tick carries last.
        if (hits > 0) begin
          r = awaited_results.pop_back();
          r.last = 1'b1;
          awaited_results.push_back(r);
        end
      end
      ACT_REGISTER: begin
        for (i = 0; i < NT; i++) begin
          if (!found && !timer_registered[i]) begin
            found = 1'b1;
            timer_registered[i] = 1'b1;
            timer_running[i] = 1'b0;
            timer_periodic[i] = 1'b0;
            timer_notify[i] = 1'b0;
            timer_period[i] = '0;
            timer_count[i] = '0;
            r.slot = i[2:0];
          end
        end
        if (!found)
          r.status = ST_NO_FREE;
        awaited_results.push_back(r);
      end
      ACT_UNREGISTER: begin
        timer_registered[idx] = 1'b0;
        timer_running[idx] = 1'b0;
        timer_notify[idx] = 1'b0;
        awaited_results.push_back(r);
      end
      ACT_START: begin
        if (!timer_registered[idx] || period == 32'd0) begin
          r.status = ST_REJECT;
        end else begin
          timer_periodic[idx] = per;
          timer_period[idx] = period;
          timer_count[idx] = '0;
          timer_running[idx] = 1'b1;
        end
        awaited_results.push_back(r);
      end
      ACT_STOP: begin
        timer_running[idx] = 1'b0;
        timer_count[idx] = '0;
        awaited_results.push_back(r);
      end
      ACT_NOTIFY: begin
        timer_notify[idx] = ntf;
        awaited_results.push_back(r);
      end
      default: begin
        // Spare codes leave the bank untouched and give nothing.
      end
    endcase
  endfunction

  // Offer one command on the slave side and predict it once it is taken.
  task automatic send_pool_command(input logic [2:0] act, input logic [2:0] idx,
                                   input logic per, input logic [31:0] period,
                                   input logic ntf);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {3'b000, ntf, period, per, idx};
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    apply_pool_command(act, idx, per, period, ntf);
  endtask

  // Withdraw the stream and let every awaited result and the last sweep drain.
  task automatic settle_pool();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (2 * SWEEP_CYCLES) @(posedge clk);
  endtask

  // Write the tick step while the bank is idle.
  task automatic write_step(input logic [STEP_W-1:0] step);
    settle_pool();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= step;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_model = step;
  endtask

  // Commands on a mostly registered pool, with periods scaled to the step.
  task automatic send_random_command(output logic counted);
    int          pick;
    int          live [$];
    int          i;
    logic [2:0]  act;
    logic [2:0]  idx;
    logic [31:0] period;
    pick = $urandom_range(99);
    if (pick < 40)
      act = ACT_TICK;
    else if (pick < 50)
      act = ACT_REGISTER;
    else if (pick < 57)
      act = ACT_UNREGISTER;
    else if (pick < 75)
      act = ACT_START;
    else if (pick < 81)
      act = ACT_STOP;
    else if (pick < 95)
      act = ACT_NOTIFY;
    else
      act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
    for (i = 0; i < NT; i++)
      if (timer_registered[i])
        live.push_back(i);
    if (live.size() > 0 && $urandom_range(99) < 80)
      idx = 3'(live[$urandom_range(live.size() - 1)]);
    else
      idx = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 10)
      period = 32'd0;
    else if (pick < 20)
      period = $urandom;
    else if (pick < 25)
      period = 32'hFFFF_FFFF - 32'($urandom_range(15));
    else
      period = 32'($urandom_range(1, 4 * int'(step_model) + 4));
    send_pool_command(act, idx, 1'($urandom_range(1)), period, $urandom_range(99) < 75);
    counted = (act != ACT_SPARE_6) && (act != ACT_SPARE_7);
  endtask

  // Each command kind, pool full, unregistered timers, extreme periods and spare codes.
  task automatic test_directed_commands();
    int i;
    write_step(10'd1);
    send_pool_command(ACT_TICK, 3'd0, 1'b0, 32'd0, 1'b0);
    for (i = 0; i <= NT; i++)
      send_pool_command(ACT_REGISTER, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_pool_command(ACT_UNREGISTER, 3'd3, 1'b0, 32'd0, 1'b0);
    send_pool_command(ACT_START, 3'd3, 1'b0, 32'd5, 1'b0);
    send_pool_command(ACT_STOP, 3'd3, 1'b0, 32'd0, 1'b0);
    send_pool_command(ACT_NOTIFY, 3'd3, 1'b0, 32'd0, 1'b1);
    send_pool_command(ACT_START, 3'd0, 1'b1, 32'd0, 1'b0);
    send_pool_command(ACT_START, 3'd0, 1'b1, 32'd1, 1'b0);
    send_pool_command(ACT_START, 3'd7, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_pool_command(ACT_START, 3'd1, 1'b0, 32'd2, 1'b0);
    send_pool_command(ACT_NOTIFY, 3'd0, 1'b0, 32'd0, 1'b1);
    send_pool_command(ACT_NOTIFY, 3'd1, 1'b0, 32'd0, 1'b1);
    send_pool_command(ACT_TICK, 3'd0, 1'b0, 32'd0, 1'b0);
    send_pool_command(ACT_TICK, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_pool_command(ACT_STOP, 3'd0, 1'b0, 32'd0, 1'b0);
    send_pool_command(ACT_SPARE_6, 3'd0, 1'b0, 32'd0, 1'b0);
    send_pool_command(ACT_SPARE_7, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_pool_command(ACT_REGISTER, 3'd0, 1'b0, 32'd0, 1'b0);
  endtask

  // All eight timers expiring on one tick, then only the periodic ones.
  task automatic test_full_expiry_burst();
    int i;
    for (i = 0; i < NT; i++) begin
      send_pool_command(ACT_NOTIFY, 3'(i), 1'b0, 32'd0, 1'b1);
      send_pool_command(ACT_START, 3'(i), 1'(i), 32'd1, 1'b0);
    end
    send_pool_command(ACT_TICK, 3'd0, 1'b0, 32'd0, 1'b0);
    send_pool_command(ACT_TICK, 3'd0, 1'b0, 32'd0, 1'b0);
  endtask

  // Random traffic under one tick step and one idling pattern.
  task automatic test_random_traffic(input int count, input logic [STEP_W-1:0] step,
                                     input int idle_pct, input int stall_pct);
    int   done;
    logic counted;
    write_step(step);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < count) begin
      send_random_command(counted);
      if (counted)
        done++;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Test sequence.
  initial begin
    for (int i = 0; i < NT; i++) begin
      timer_registered[i] = 1'b0;
      timer_running[i] = 1'b0;
      timer_periodic[i] = 1'b0;
      timer_notify[i] = 1'b0;
      timer_period[i] = '0;
      timer_count[i] = '0;
    end
    step_model = STEP_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_full_expiry_burst();
    test_random_traffic(55, 10'd1, 0, 0);
    test_random_traffic(50, 10'd1023, 70, 0);
    test_random_traffic(35, 10'd0, 0, 70);
    test_random_traffic(70, 10'($urandom_range(2, 40)), 8, 8);
    settle_pool();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
